FILE: rtl/evhp_pkg.sv
// shared types, constants and helpers for the ethernet vlan header parser
package evhp_pkg;

    // default width of the frame length count
    localparam int DEF_LENGTH_BITS = 16;

    // tag protocol identifiers that open a vlan tag
    localparam logic [15:0] TPID_CTAG   = 16'h8100;
    localparam logic [15:0] TPID_STAG_1 = 16'h9100;
    localparam logic [15:0] TPID_STAG_2 = 16'h9200;
    localparam logic [15:0] TPID_STAG_3 = 16'h9300;

    // header geometry
    localparam logic [4:0] HDR_BASE_BYTES = 5'd14;
    localparam logic [4:0] HDR_MAX_BYTES  = 5'd22;
    localparam logic [1:0] TAGS_TOO_MANY  = 2'd3;

    // byte offsets inside the header
    localparam logic [4:0] POS_SRC_START  = 5'd6;
    localparam logic [4:0] POS_TYPE_START = 5'd12;
    localparam logic [4:0] POS_TYPE_0     = 5'd13;
    localparam logic [4:0] POS_TCI1_HI    = 5'd14;
    localparam logic [4:0] POS_TCI1_LO    = 5'd15;
    localparam logic [4:0] POS_TYPE_1     = 5'd17;
    localparam logic [4:0] POS_TCI2_HI    = 5'd18;
    localparam logic [4:0] POS_TCI2_LO    = 5'd19;
    localparam logic [4:0] POS_TYPE_2     = 5'd21;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT = 2'd1;
    localparam logic [1:0] ST_TAG_LIMIT = 2'd2;

    // one frame byte request
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_req;

    // one parsed header request
    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] payload_type;
        logic [15:0] outer_tag_id;
        logic [15:0] outer_tag_control;
        logic [15:0] inner_tag_id;
        logic [15:0] inner_tag_control;
        logic [4:0]  header_bytes;
        logic [15:0] payload_bytes;
    } t_out_req;

    // true for any vlan tag identifier
    function automatic logic is_tpid(input logic [15:0] t);
        return (t == TPID_CTAG) || (t == TPID_STAG_1) ||
               (t == TPID_STAG_2) || (t == TPID_STAG_3);
    endfunction

endpackage

FILE: rtl/evhp_parse_core.sv
// parse state: field capture, tag tracking, length count and result forming
module evhp_parse_core import evhp_pkg::*; #(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_req  i_req,
    output t_out_req o_res
);

    localparam int POS_W = LENGTH_BITS + 1;
    localparam logic [POS_W-1:0] LEN_MAX = {1'b0, {LENGTH_BITS{1'b1}}};
    localparam logic [POS_W-1:0] POS_CAP = LEN_MAX + POS_W'(32);
    localparam logic [POS_W-1:0] PAY_MAX =
        (LENGTH_BITS >= 16) ? POS_W'(17'h0FFFF) : LEN_MAX;

    logic [POS_W-1:0] r_pos,      n_pos;
    logic [47:0]      r_dest,     n_dest;
    logic [47:0]      r_src,      n_src;
    logic [15:0]      r_type,     n_type;
    logic [1:0]       r_tags,     n_tags;
    logic [15:0]      r_tag1_id,  n_tag1_id;
    logic [15:0]      r_tag1_ctl, n_tag1_ctl;
    logic [15:0]      r_tag2_id,  n_tag2_id;
    logic [15:0]      r_tag2_ctl, n_tag2_ctl;
    logic             r_hdr_done, n_hdr_done;

    logic             in_hdr;
    logic [4:0]       pos5;
    logic [4:0]       hdr_len;
    logic [POS_W-1:0] pay;

    // header field capture for the current byte
    always_comb begin
        n_dest     = r_dest;
        n_src      = r_src;
        n_type     = r_type;
        n_tags     = r_tags;
        n_tag1_id  = r_tag1_id;
        n_tag1_ctl = r_tag1_ctl;
        n_tag2_id  = r_tag2_id;
        n_tag2_ctl = r_tag2_ctl;
        n_hdr_done = r_hdr_done;
        in_hdr     = !r_hdr_done && (r_pos < POS_W'(HDR_MAX_BYTES));
        pos5       = r_pos[4:0];
        if (in_hdr) begin
            priority if (pos5 < POS_SRC_START) begin
                n_dest = {r_dest[39:0], i_req.frame_byte};
            end else if (pos5 < POS_TYPE_START) begin
                n_src = {r_src[39:0], i_req.frame_byte};
            end else if (pos5 == POS_TCI1_HI || pos5 == POS_TCI1_LO) begin
                n_tag1_ctl = {r_tag1_ctl[7:0], i_req.frame_byte};
            end else if (pos5 == POS_TCI2_HI || pos5 == POS_TCI2_LO) begin
                n_tag2_ctl = {r_tag2_ctl[7:0], i_req.frame_byte};
            end else begin
                n_type = {r_type[7:0], i_req.frame_byte};
                // a type word is complete: either a tag or the payload type
                if (pos5 == POS_TYPE_0 || pos5 == POS_TYPE_1 || pos5 == POS_TYPE_2) begin
                    if (!is_tpid(n_type)) begin
                        n_hdr_done = 1'b1;
                    end else begin
                        unique case (r_tags)
                            2'd0: begin
                                n_tag1_id = n_type;
                                n_tags    = 2'd1;
                            end
                            2'd1: begin
                                n_tag2_id = n_type;
                                n_tags    = 2'd2;
                            end
                            default: begin
                                n_tags     = TAGS_TOO_MANY;
                                n_hdr_done = 1'b1;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // saturating byte count
    always_comb begin
        n_pos = (r_pos < POS_CAP) ? r_pos + POS_W'(1) : r_pos;
    end

    // result for a frame ending on this byte
    always_comb begin
        hdr_len = HDR_BASE_BYTES + {1'b0, n_tags, 2'b00};
        pay     = n_pos - POS_W'(hdr_len);
        if (pay > PAY_MAX) begin
            pay = PAY_MAX;
        end
        o_res = '0;
        priority if (n_hdr_done && n_tags == TAGS_TOO_MANY) begin
            o_res.status            = ST_TAG_LIMIT;
            o_res.dest_mac          = n_dest;
            o_res.source_mac        = n_src;
            o_res.outer_tag_id      = n_tag1_id;
            o_res.outer_tag_control = n_tag1_ctl;
            o_res.inner_tag_id      = n_tag2_id;
            o_res.inner_tag_control = n_tag2_ctl;
        end else if (!n_hdr_done || n_pos <= POS_W'(hdr_len)) begin
            o_res.status = ST_TOO_SHORT;
        end else begin
            o_res.status       = ST_OK;
            o_res.dest_mac     = n_dest;
            o_res.source_mac   = n_src;
            o_res.payload_type = n_type;
            if (n_tags == 2'd2) begin
                o_res.outer_tag_id      = n_tag1_id;
                o_res.outer_tag_control = n_tag1_ctl;
                o_res.inner_tag_id      = n_tag2_id;
                o_res.inner_tag_control = n_tag2_ctl;
            end else if (n_tags == 2'd1) begin
                o_res.inner_tag_id      = n_tag1_id;
                o_res.inner_tag_control = n_tag1_ctl;
            end
            o_res.header_bytes  = hdr_len;
            o_res.payload_bytes = 16'(pay);
        end
    end

    // parse state, cleared after every frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_req.frame_end)) begin
            r_pos      <= '0;
            r_dest     <= '0;
            r_src      <= '0;
            r_type     <= '0;
            r_tags     <= '0;
            r_tag1_id  <= '0;
            r_tag1_ctl <= '0;
            r_tag2_id  <= '0;
            r_tag2_ctl <= '0;
            r_hdr_done <= 1'b0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_dest     <= n_dest;
            r_src      <= n_src;
            r_type     <= n_type;
            r_tags     <= n_tags;
            r_tag1_id  <= n_tag1_id;
            r_tag1_ctl <= n_tag1_ctl;
            r_tag2_id  <= n_tag2_id;
            r_tag2_ctl <= n_tag2_ctl;
            r_hdr_done <= n_hdr_done;
        end
    end

endmodule

FILE: rtl/ethernet_vlan_header_parser.sv
// top level of the ethernet 802.1q / qinq header parser
//
//  channel | direction | signals                                | moves
//  --------+-----------+----------------------------------------+----------------------
//  in      | to block  | i_in_valid, o_in_stall, i_in_req       | one frame byte
//  out     | from block| o_out_valid, i_out_stall, o_out_req    | one header result
//
//  one frame byte is taken every cycle while the result side is not stalled;
//  a result is presented after the last byte of its frame is taken, passing through
//  the input register and then the result register.
//  reset (i_rst_n low, synchronous) empties both stages and clears the parse state.
//  a stalled result holds the result register; the input side keeps taking a
//  byte into a skid register and stalls only once that is full.
module ethernet_vlan_header_parser import evhp_pkg::*; #(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    logic     r_in_valid;
    t_in_req  r_in;
    logic     r_skid_valid;
    t_in_req  r_skid;
    logic     r_out_valid;
    t_out_req r_out;

    logic     accept;
    logic     advance;
    t_out_req res;

    // handshake control
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // parse state and result forming
    evhp_parse_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (r_in),
        .o_res   (res)
    );

    // input register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (advance) begin
            if (r_skid_valid) begin
                r_in         <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_in_valid <= accept;
                r_in       <= i_in_req;
            end
        end else if (!r_in_valid) begin
            r_in_valid <= accept;
            r_in       <= i_in_req;
        end else if (accept) begin
            r_skid       <= i_in_req;
            r_skid_valid <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.frame_end) begin
            r_out_valid <= 1'b1;
            r_out       <= res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: verif/tb_ethernet_vlan_header_parser.sv
// testbench for the ethernet vlan header parser: frame stimulus, predicted headers, flow control
module tb_ethernet_vlan_header_parser;
    import evhp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 200;
    localparam int PHASE_FRAMES   = 10;

    localparam logic [15:0] TAG_IDS [4] = '{TPID_CTAG, TPID_STAG_1, TPID_STAG_2, TPID_STAG_3};

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    // parse state mirror and the queue of header results still due
    class header_result_board;
        localparam int unsigned LEN_MAX = (1 << DEF_LENGTH_BITS) - 1;
        localparam int unsigned POS_CAP = LEN_MAX + 32;
        localparam int unsigned PAY_MAX = 16'hFFFF;

        int unsigned pos;
        logic [47:0] dest;
        logic [47:0] src;
        logic [15:0] ethertype;
        logic [15:0] tag_a_id;
        logic [15:0] tag_a_ctl;
        logic [15:0] tag_b_id;
        logic [15:0] tag_b_ctl;
        int unsigned tags;
        bit          hdr_done;
        t_out_req    due_headers[$];
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        static function bit is_tag_id(logic [15:0] t);
            return t == TPID_CTAG || t == TPID_STAG_1 || t == TPID_STAG_2 || t == TPID_STAG_3;
        endfunction

        function void clear();
            pos       = 0;
            dest      = '0;
            src       = '0;
            ethertype = '0;
            tag_a_id  = '0;
            tag_a_ctl = '0;
            tag_b_id  = '0;
            tag_b_ctl = '0;
            tags      = 0;
            hdr_done  = 1'b0;
        endfunction

        // one accepted byte request; on the last byte a header result falls due
        function void take_byte(t_in_req req);
            t_out_req    want;
            int unsigned hdr;
            int unsigned pay;
            // field capture while the header is still open
            if (!hdr_done && pos < HDR_MAX_BYTES) begin
                if (pos < POS_SRC_START) begin
                    dest = {dest[39:0], req.frame_byte};
                end else if (pos < POS_TYPE_START) begin
                    src = {src[39:0], req.frame_byte};
                end else if (pos == POS_TCI1_HI || pos == POS_TCI1_LO) begin
                    tag_a_ctl = {tag_a_ctl[7:0], req.frame_byte};
                end else if (pos == POS_TCI2_HI || pos == POS_TCI2_LO) begin
                    tag_b_ctl = {tag_b_ctl[7:0], req.frame_byte};
                end else begin
                    ethertype = {ethertype[7:0], req.frame_byte};
                    // a whole type word either opens another tag or closes the header
                    if (pos == POS_TYPE_0 || pos == POS_TYPE_1 || pos == POS_TYPE_2) begin
                        if (!is_tag_id(ethertype)) begin
                            hdr_done = 1'b1;
                        end else if (tags == 0) begin
                            tag_a_id = ethertype;
                            tags     = 1;
                        end else if (tags == 1) begin
                            tag_b_id = ethertype;
                            tags     = 2;
                        end else begin
                            tags     = TAGS_TOO_MANY;
                            hdr_done = 1'b1;
                        end
                    end
                end
            end
            if (pos < POS_CAP) pos++;
            if (!req.frame_end) return;

            want = '0;
            hdr  = HDR_BASE_BYTES + 4 * tags;
            if (hdr_done && tags == TAGS_TOO_MANY) begin
                // third tag: addresses and both tags, no lengths
                want.status            = ST_TAG_LIMIT;
                want.dest_mac          = dest;
                want.source_mac        = src;
                want.outer_tag_id      = tag_a_id;
                want.outer_tag_control = tag_a_ctl;
                want.inner_tag_id      = tag_b_id;
                want.inner_tag_control = tag_b_ctl;
            end else if (!hdr_done || pos <= hdr) begin
                want.status = ST_TOO_SHORT;
            end else begin
                want.status       = ST_OK;
                want.dest_mac     = dest;
                want.source_mac   = src;
                want.payload_type = ethertype;
                if (tags == 2) begin
                    want.outer_tag_id      = tag_a_id;
                    want.outer_tag_control = tag_a_ctl;
                    want.inner_tag_id      = tag_b_id;
                    want.inner_tag_control = tag_b_ctl;
                end else if (tags == 1) begin
                    want.inner_tag_id      = tag_a_id;
                    want.inner_tag_control = tag_a_ctl;
                end
                want.header_bytes = hdr[4:0];
                pay = pos - hdr;
                if (pay > LEN_MAX) pay = LEN_MAX;
                if (pay > PAY_MAX) pay = PAY_MAX;
                want.payload_bytes = pay[15:0];
            end
            due_headers.push_back(want);
            clear();
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // one accepted header result against the oldest one due
        function void check_header(t_out_req got);
            t_out_req want;
            if (due_headers.size() == 0) begin
                $display("%0t: header result with none due, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = due_headers.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("dest_mac", want.dest_mac, got.dest_mac);
            compare_field("source_mac", want.source_mac, got.source_mac);
            compare_field("payload_type", want.payload_type, got.payload_type);
            compare_field("outer_tag_id", want.outer_tag_id, got.outer_tag_id);
            compare_field("outer_tag_control", want.outer_tag_control, got.outer_tag_control);
            compare_field("inner_tag_id", want.inner_tag_id, got.inner_tag_id);
            compare_field("inner_tag_control", want.inner_tag_control, got.inner_tag_control);
            compare_field("header_bytes", want.header_bytes, got.header_bytes);
            compare_field("payload_bytes", want.payload_bytes, got.payload_bytes);
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_req o_out_req;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int holds_asked   = 0;
    int holds_granted = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    logic [7:0]         frame_octets[$];
    header_result_board board = new();

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    ethernet_vlan_header_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    // result side: check each accepted header, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_header(o_out_req);
        if (holds_granted != holds_asked) begin
            holds_granted = holds_asked;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [7:0] fill_byte(t_fill fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom());
        endcase
    endfunction

    // offer one byte request after a random gap and hold it until taken
    task automatic send_byte(input t_in_req req);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        board.take_byte(req);
    endtask

    // build a frame of len bytes with the given tags, then send it
    task automatic send_frame(input int tags, input bit third, input int len, input t_fill fill,
                              input int first_tpid = -1);
        logic [15:0] ty;
        t_in_req     req;
        frame_octets.delete();
        repeat (12) frame_octets.push_back(fill_byte(fill));
        for (int t = 0; t < tags + int'(third); t++) begin
            ty = (t == 0 && first_tpid >= 0) ? TAG_IDS[first_tpid] : TAG_IDS[$urandom_range(3)];
            frame_octets.push_back(ty[15:8]);
            frame_octets.push_back(ty[7:0]);
            if (t < tags) begin
                frame_octets.push_back(fill_byte(fill));
                frame_octets.push_back(fill_byte(fill));
            end
        end
        // closing type word, often a near miss of a tag identifier
        if (!third) begin
            case (fill)
                FILL_ZERO: ty = 16'h0000;
                FILL_ONES: ty = 16'hFFFF;
                default: begin
                    do begin
                        case ($urandom_range(3))
                            0:       ty = TAG_IDS[$urandom_range(3)] ^ (16'h0001 << $urandom_range(15));
                            1:       ty = 16'h0800;
                            default: ty = 16'($urandom());
                        endcase
                    end while (header_result_board::is_tag_id(ty));
                end
            endcase
            frame_octets.push_back(ty[15:8]);
            frame_octets.push_back(ty[7:0]);
        end
        while (frame_octets.size() < len) frame_octets.push_back(fill_byte(fill));
        while (frame_octets.size() > len) void'(frame_octets.pop_back());
        foreach (frame_octets[i]) begin
            req.frame_byte = frame_octets[i];
            req.frame_end  = (i == frame_octets.size() - 1);
            send_byte(req);
        end
    endtask

    initial begin
        int    pick;
        int    shape;
        int    tags;
        bit    third;
        int    hdr;
        int    len;
        int    phase_bytes;
        int    phase_frames;
        t_fill fill;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        send_frame(0, 0, 1, FILL_RANDOM);      // frame ends on its first byte
        send_frame(0, 0, 8, FILL_RANDOM);      // ends inside the source address
        send_frame(0, 0, 14, FILL_RANDOM);     // no byte past the header
        send_frame(0, 0, 15, FILL_ZERO);
        send_frame(0, 0, 15, FILL_ONES);
        for (int k = 0; k < 4; k++) send_frame(1, 0, 19 + k, FILL_RANDOM, k);
        send_frame(1, 0, 16, FILL_RANDOM);     // ends inside the tag
        send_frame(1, 0, 18, FILL_RANDOM);     // one tag, no payload
        send_frame(2, 0, 22, FILL_RANDOM);     // two tags, no payload
        send_frame(2, 0, 23, FILL_ONES);
        send_frame(2, 0, 23, FILL_ZERO);
        send_frame(2, 1, 21, FILL_RANDOM);     // third tag cut short
        send_frame(2, 1, 22, FILL_RANDOM);     // third tag, nothing after
        send_frame(2, 1, 40, FILL_RANDOM);     // third tag, long frame
        send_frame(0, 0, 15, FILL_RANDOM);     // state cleared after the third tag

        // random frames under each flow control setting
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 56; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 56; end
                3:       begin idle_pct = 38; stall_pct = 38; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            phase_bytes  = 0;
            phase_frames = 0;
            while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
                // long receiver hold-off while the sender keeps offering
                if (phase == 4 && (phase_frames == 0 || phase_frames == 5)) holds_asked++;
                pick  = $urandom_range(99);
                shape = $urandom_range(99);
                tags  = $urandom_range(2);
                third = (pick < 8);
                if (third) tags = 2;
                hdr = third ? int'(HDR_MAX_BYTES) : int'(HDR_BASE_BYTES) + 4 * tags;
                if (pick >= 95)       len = $urandom_range(30, 1);
                else if (shape < 15)  len = $urandom_range(hdr, 1);
                else if (shape < 20)  len = hdr + $urandom_range(120, 21);
                else                  len = hdr + $urandom_range(20, 1);
                pick = $urandom_range(99);
                fill = (pick < 3) ? FILL_ZERO : (pick < 6) ? FILL_ONES : FILL_RANDOM;
                send_frame(tags, third, len, fill);
                phase_bytes += len;
                phase_frames++;
            end
        end
        i_in_valid <= 1'b0;

        // drain
        while (board.due_headers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/evhp_pkg.sv
rtl/evhp_parse_core.sv
rtl/ethernet_vlan_header_parser.sv
verif/tb_ethernet_vlan_header_parser.sv
